>>> src/cusf_pkg.sv
// Package with shared constants, types and basis descriptor table for the cubic shape unit.
`default_nettype none
package cusf_pkg;
  localparam int unsigned QB = 24;
  localparam int unsigned BIDX_W = 4;

  // Table entry: which factor each axis omits, sign and divisor code.
  typedef struct packed {
    logic [1:0] rsel;
    logic [1:0] ssel;
    logic       neg;
    logic [1:0] dsel;
  } basis_t;

  typedef enum logic [1:0] {
    DIV_1 = 2'd0,
    DIV_3 = 2'd1,
    DIV_9 = 2'd2
  } div_e;

  // Per-axis polynomial set in Q24. In-range points keep every value below 64 in magnitude.
  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic signed [31:0] d0;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic signed [31:0] d3;
  } axis_t;

  function automatic basis_t basis_lut(input logic [BIDX_W-1:0] idx);
    basis_t b;
    unique case (idx)
      4'd0:  b = '{2'd0, 2'd1, 1'b0, DIV_3};
      4'd1:  b = '{2'd0, 2'd0, 1'b0, DIV_9};
      4'd2:  b = '{2'd1, 2'd0, 1'b0, DIV_3};
      4'd3:  b = '{2'd1, 2'd1, 1'b0, DIV_1};
      4'd4:  b = '{2'd2, 2'd0, 1'b1, DIV_3};
      4'd5:  b = '{2'd3, 2'd0, 1'b0, DIV_9};
      4'd6:  b = '{2'd3, 2'd1, 1'b0, DIV_3};
      4'd7:  b = '{2'd2, 2'd1, 1'b1, DIV_1};
      4'd8:  b = '{2'd3, 2'd2, 1'b1, DIV_3};
      4'd9:  b = '{2'd2, 2'd2, 1'b0, DIV_1};
      4'd10: b = '{2'd1, 2'd2, 1'b1, DIV_1};
      4'd11: b = '{2'd3, 2'd3, 1'b0, DIV_9};
      4'd12: b = '{2'd2, 2'd3, 1'b1, DIV_3};
      4'd13: b = '{2'd1, 2'd3, 1'b0, DIV_3};
      4'd14: b = '{2'd0, 2'd3, 1'b0, DIV_9};
      default: b = '{2'd0, 2'd2, 1'b1, DIV_3};
    endcase
    return b;
  endfunction

  // Q24 product rounded to nearest, ties away from zero.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [63:0] p;
    logic [63:0] m;
    logic [63:0] r;
    p = a * b;
    m = p[63] ? 64'(-p) : 64'(p);
    r = (m + (64'd1 << (QB - 1))) >> QB;
    return p[63] ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction
endpackage
`default_nettype wire

>>> src/cusf_axis.sv
// Three-stage pipeline that forms the four cubics and derivatives of one axis.
`default_nettype none
module cusf_axis import cusf_pkg::*; #(
  parameter int unsigned CoordFracBits = 16
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [19:0] coord_i,
  output axis_t                   axis_o
);
  logic signed [31:0] m1_q, p1_q, p3_q, p5_q, t8_q, tx_q;
  logic signed [43:0] xw;
  logic signed [31:0] x;
  logic signed [31:0] p35_q, pm_q, p13_q, m3_q, p1m1_q;
  logic signed [31:0] a_p5_q, a_p3_q, a_m1_q, a_p1_q, a_t8_q, a_tx_q;

  // Out-of-range points may wrap here; their results are discarded at the output.
  assign xw = 44'(coord_i) <<< (QB - CoordFracBits);
  assign x  = xw[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= (32'sd1 <<< QB) - x;
      p1_q <= (32'sd1 <<< QB) + x;
      p3_q <= (32'sd3 <<< QB) + x;
      p5_q <= (32'sd5 <<< QB) + x;
      t8_q <= (x <<< 1) + (32'sd8 <<< QB);
      tx_q <= x <<< 1;
      // First product layer.
      p35_q  <= qmul(p3_q, p5_q);
      pm_q   <= qmul(p1_q, m1_q);
      p13_q  <= qmul(p1_q, p3_q);
      m3_q   <= qmul(m1_q, p3_q);
      p1m1_q <= qmul(p1_q, m1_q);
      a_p5_q <= p5_q;
      a_p3_q <= p3_q;
      a_m1_q <= m1_q;
      a_p1_q <= p1_q;
      a_t8_q <= t8_q;
      a_tx_q <= tx_q;
      // Second product layer and derivative sums.
      axis_o.c0 <= qmul(p13_q, a_p5_q);
      axis_o.c1 <= qmul(m3_q, a_p5_q);
      axis_o.c2 <= qmul(p1m1_q, a_p5_q);
      axis_o.c3 <= qmul(p1m1_q, a_p3_q);
      axis_o.d0 <= p35_q + qmul(a_p1_q, a_t8_q);
      axis_o.d1 <= -p35_q + qmul(a_m1_q, a_t8_q);
      axis_o.d2 <= pm_q - qmul(a_tx_q, a_p5_q);
      axis_o.d3 <= pm_q - qmul(a_tx_q, a_p3_q);
    end
  end
endmodule
`default_nettype wire

>>> src/cusf_combine.sv
// Pipelined product, rounded divide by k times a power of two, sign and saturation.
`default_nettype none
module cusf_combine import cusf_pkg::*; #(
  parameter int unsigned ValueFracBits = 20
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  input  wire logic [1:0]         dsel_i,
  input  wire logic               neg_i,
  output logic [31:0]             res_o
);
  localparam int unsigned Sh = 56 - ValueFracBits;
  // Reciprocals of 3 and 9 scaled by 2^33; the quotient is exact for any 32-bit dividend.
  localparam logic [31:0] Recip3 = 32'hAAAA_AAAB;
  localparam logic [31:0] Recip9 = 32'h38E3_8E39;
  logic [31:0] ma_q, mb_q;
  logic        sgn_q, sgn2_q, sgn3_q;
  logic [1:0]  ds_q, ds2_q, ds3_q;
  logic [63:0] prod_q, prod2_q;
  logic [63:0] xs;
  logic [31:0] xq;
  logic [31:0] rsel;
  logic [63:0] recip;
  logic [31:0] quo;
  logic [31:0] q0_q;
  logic [35:0] qk;
  logic [63:0] dvs;
  logic [63:0] rem;
  logic [32:0] q;

  // Truncated quotient: prod / 2^Sh, then divided by k through the reciprocal.
  assign xs    = prod_q >> Sh;
  assign xq    = xs[31:0];
  assign rsel  = (ds2_q == DIV_9) ? Recip9 : Recip3;
  assign recip = xq * rsel;
  assign quo   = (ds2_q == DIV_1) ? xq : 32'(recip >> 33);

  always_comb begin
    unique case (ds3_q)
      DIV_3: begin
        qk  = 36'(q0_q) + (36'(q0_q) << 1);
        dvs = 64'd3 << Sh;
      end
      DIV_9: begin
        qk  = 36'(q0_q) + (36'(q0_q) << 3);
        dvs = 64'd9 << Sh;
      end
      default: begin
        qk  = 36'(q0_q);
        dvs = 64'd1 << Sh;
      end
    endcase
    rem = prod2_q - (64'(qk) << Sh);
    q   = {1'b0, q0_q};
    if ((rem << 1) >= dvs) q = {1'b0, q0_q} + 33'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q    <= a_i[31] ? 32'(-a_i) : 32'(a_i);
      mb_q    <= b_i[31] ? 32'(-b_i) : 32'(b_i);
      sgn_q   <= (a_i[31] ^ b_i[31]) ^ neg_i;
      ds_q    <= dsel_i;
      prod_q  <= ma_q * mb_q;
      sgn2_q  <= sgn_q;
      ds2_q   <= ds_q;
      q0_q    <= quo;
      prod2_q <= prod_q;
      ds3_q   <= ds2_q;
      sgn3_q  <= sgn2_q;
      if (sgn3_q) res_o <= (q >= 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-q);
      else res_o <= (q >= 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
  end
endmodule
`default_nettype wire

>>> src/cubic_upwind_shape_functions.sv
// Top level: point intake, per-index sequencer, shape pipeline and output register.
// Usage: present coord_r_i, coord_s_i and skip_derivatives_i with in_valid_i;
// an item is taken when in_valid_i and in_ready_o are both high. Each in-range
// point gives sixteen result items, basis_index 0 to 15, last_o on index 15.
// An out-of-range point gives a single item with status_o set and last_o set.
// The sequencer issues one basis index per cycle while the pipeline is not
// held; in_ready_o rises again once index 15 has issued and the pipeline is
// not held, so a new point enters only after every index of the previous
// point has issued. Results flow through a pipeline of seven stages with
// valid bits; when out_valid_o is high and out_ready_i is low the whole
// pipeline holds and nothing is lost.
// Reset clears all valid bits and the sequencer; no item is then pending.
`default_nettype none
module cubic_upwind_shape_functions import cusf_pkg::*; #(
  parameter int unsigned CoordFracBits = 16,
  parameter int unsigned ValueFracBits = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [19:0] coord_r_i,
  input  wire logic signed [19:0] coord_s_i,
  input  wire logic               skip_derivatives_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    status_o,
  output logic [3:0]              basis_index_o,
  output logic signed [31:0]      shape_value_o,
  output logic signed [31:0]      deriv_r_o,
  output logic signed [31:0]      deriv_s_o,
  output logic                    derivs_valid_o,
  output logic                    last_o
);
  localparam int unsigned Depth = 7;
  localparam logic signed [31:0] Lo = -(32'sd5 <<< CoordFracBits) - 32'sd1;
  localparam logic signed [31:0] Hi = (32'sd1 <<< CoordFracBits) + 32'sd1;

  typedef struct packed {
    logic       err;
    logic [3:0] idx;
    logic       skip;
    logic       last;
  } tag_t;

  logic en;
  logic [Depth-1:0] vld_q;
  tag_t tag_q [Depth];
  logic busy_q;
  logic [3:0] idx_q;
  logic skip_q;
  logic issue;
  logic take;
  logic v_in;
  tag_t tag_in;
  logic bad;
  axis_t ar, as;
  basis_t bd;
  basis_t bd_q [3];
  logic [31:0] rc, rd, sc, sd;
  logic [31:0] sv, dr, ds;
  logic signed [19:0] r_q, s_q;
  tag_t t;

  assign en = !out_valid_o || out_ready_i;
  assign bad = ($signed(32'(coord_r_i)) < Lo) || ($signed(32'(coord_r_i)) > Hi) ||
               ($signed(32'(coord_s_i)) < Lo) || ($signed(32'(coord_s_i)) > Hi);
  assign in_ready_o = en && (!busy_q || idx_q == 4'd15);
  assign take = in_valid_i && in_ready_o;
  assign issue = busy_q && en;

  // Stage 0 tag: a new point enters either as an error or as index 0; otherwise the next index follows.
  always_comb begin
    tag_in = '0;
    if (take) begin
      tag_in.err  = bad;
      tag_in.skip = skip_derivatives_i;
      tag_in.last = bad;
    end else begin
      tag_in.idx  = idx_q + 4'd1;
      tag_in.skip = skip_q;
      tag_in.last = (idx_q == 4'd14);
    end
  end

  assign v_in = take || (busy_q && idx_q != 4'd15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      skip_q <= 1'b0;
      vld_q  <= '0;
    end else if (en) begin
      if (take) begin
        busy_q <= !bad;
        idx_q  <= '0;
        skip_q <= skip_derivatives_i;
      end else if (issue) begin
        if (idx_q == 4'd15) busy_q <= 1'b0;
        else idx_q <= idx_q + 4'd1;
      end
      vld_q <= {vld_q[Depth-2:0], v_in};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0] <= tag_in;
      for (int i = 1; i < Depth; i++) tag_q[i] <= tag_q[i-1];
      bd_q[0] <= basis_lut(tag_in.idx);
      bd_q[1] <= bd_q[0];
      bd_q[2] <= bd_q[1];
    end
  end

  // Axis pipelines hold coordinates of the current point; hold register on intake.
  always_ff @(posedge clk_i) begin
    if (take) begin
      r_q <= coord_r_i;
      s_q <= coord_s_i;
    end
  end

  cusf_axis #(.CoordFracBits(CoordFracBits)) u_ax_r (
    .clk_i(clk_i), .en_i(en), .coord_i(take ? coord_r_i : r_q), .axis_o(ar));
  cusf_axis #(.CoordFracBits(CoordFracBits)) u_ax_s (
    .clk_i(clk_i), .en_i(en), .coord_i(take ? coord_s_i : s_q), .axis_o(as));

  // Axis results are aligned with bd_q[2].
  assign bd = bd_q[2];
  always_comb begin
    unique case (bd.rsel)
      2'd0: begin rc = ar.c0; rd = ar.d0; end
      2'd1: begin rc = ar.c1; rd = ar.d1; end
      2'd2: begin rc = ar.c2; rd = ar.d2; end
      default: begin rc = ar.c3; rd = ar.d3; end
    endcase
    unique case (bd.ssel)
      2'd0: begin sc = as.c0; sd = as.d0; end
      2'd1: begin sc = as.c1; sd = as.d1; end
      2'd2: begin sc = as.c2; sd = as.d2; end
      default: begin sc = as.c3; sd = as.d3; end
    endcase
  end

  cusf_combine #(.ValueFracBits(ValueFracBits)) u_cv (
    .clk_i(clk_i), .en_i(en), .a_i(rc), .b_i(sc), .dsel_i(bd.dsel),
    .neg_i(bd.neg), .res_o(sv));
  cusf_combine #(.ValueFracBits(ValueFracBits)) u_cr (
    .clk_i(clk_i), .en_i(en), .a_i(rd), .b_i(sc), .dsel_i(bd.dsel),
    .neg_i(bd.neg), .res_o(dr));
  cusf_combine #(.ValueFracBits(ValueFracBits)) u_cs (
    .clk_i(clk_i), .en_i(en), .a_i(rc), .b_i(sd), .dsel_i(bd.dsel),
    .neg_i(bd.neg), .res_o(ds));

  assign t = tag_q[Depth-1];
  assign out_valid_o    = vld_q[Depth-1];
  assign status_o       = t.err;
  assign basis_index_o  = t.err ? 4'd0 : t.idx;
  assign shape_value_o  = t.err ? 32'sd0 : $signed(sv);
  assign deriv_r_o      = (t.err || t.skip) ? 32'sd0 : $signed(dr);
  assign deriv_s_o      = (t.err || t.skip) ? 32'sd0 : $signed(ds);
  assign derivs_valid_o = !(t.err || t.skip);
  assign last_o         = t.last;

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && !status_o |-> basis_index_o == 4'd15)
    else $error("last on wrong index");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o)
    else $error("error item without last");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && idx_q != 4'd15 |-> !in_ready_o)
    else $error("intake while sequencing");
endmodule
`default_nettype wire

>>> tb/cusf_checker.sv
// Checker predicting sixteen results per point, or one if out of range, and comparing.
`timescale 1ns / 100ps
module cusf_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [19:0] coord_r_i,
  input  logic signed [19:0] coord_s_i,
  input  logic               skip_derivatives_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               status_i,
  input  logic [3:0]         basis_index_i,
  input  logic signed [31:0] shape_value_i,
  input  logic signed [31:0] deriv_r_i,
  input  logic signed [31:0] deriv_s_i,
  input  logic               derivs_valid_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  localparam int CoordFrac = 16;
  localparam int ValueFrac = 20;
  localparam int QFrac = 24;

  typedef struct packed {
    logic        status;
    logic [3:0]  index;
    logic [31:0] value;
    logic [31:0] dr;
    logic [31:0] ds;
    logic        dvalid;
    logic        last;
  } shape_res_t;

  typedef logic signed [63:0] q_t;

  shape_res_t expected_q[$];

  // Omitted factor per axis, sign and divisor for each of the sixteen functions.
  function automatic void basis_row(input int idx, output int rs, output int ss,
                                    output bit ng, output int dv);
    int rt[16] = '{0, 0, 1, 1, 2, 3, 3, 2, 3, 2, 1, 3, 2, 1, 0, 0};
    int st[16] = '{1, 0, 0, 1, 0, 0, 1, 1, 2, 2, 2, 3, 3, 3, 3, 2};
    bit nt[16] = '{0, 0, 0, 0, 1, 0, 0, 1, 1, 0, 1, 0, 1, 0, 0, 1};
    int dt[16] = '{3, 9, 3, 1, 3, 9, 3, 1, 3, 1, 1, 9, 3, 3, 9, 3};
    rs = rt[idx];
    ss = st[idx];
    ng = nt[idx];
    dv = dt[idx];
  endfunction

  function automatic q_t round_q24(input q_t a, input q_t b);
    logic signed [127:0] p;
    logic [127:0] m;
    p = a * b;
    m = p[127] ? -p : p;
    m = (m + (128'd1 << (QFrac - 1))) >> QFrac;
    return p[127] ? -$signed(m[63:0]) : $signed(m[63:0]);
  endfunction

  function automatic void cubics_of(input q_t x, output q_t cub[4], output q_t der[4]);
    q_t one, m1, p1, p3, p5, t8, tx, p35, pm;
    one = q_t'(1) <<< QFrac;
    m1 = one - x;
    p1 = one + x;
    p3 = 3 * one + x;
    p5 = 5 * one + x;
    t8 = 2 * x + 8 * one;
    tx = 2 * x;
    p35 = round_q24(p3, p5);
    pm = round_q24(p1, m1);
    cub[0] = round_q24(round_q24(p1, p3), p5);
    cub[1] = round_q24(round_q24(m1, p3), p5);
    cub[2] = round_q24(pm, p5);
    cub[3] = round_q24(pm, p3);
    der[0] = p35 + round_q24(p1, t8);
    der[1] = -p35 + round_q24(m1, t8);
    der[2] = -round_q24(tx, p5) + pm;
    der[3] = -round_q24(tx, p3) + pm;
  endfunction

  // Exact product scaled down by k * 2^(56 - frac), rounded and saturated.
  function automatic logic [31:0] scale_product(input q_t a, input q_t b, input int k,
                                                input bit ng);
    bit sgn;
    logic [127:0] ma, mb, d, prod, q, rem;
    sgn = ((a < 0) != (b < 0)) != ng;
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    d = 128'(k) << (56 - ValueFrac);
    prod = ma * mb;
    q = prod / d;
    rem = prod % d;
    if (2 * rem >= d) q++;
    if (sgn) return (q >= 128'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q >= 128'h7fff_ffff) ? 32'h7fff_ffff : 32'(q);
  endfunction

  task automatic predict_point(input logic signed [19:0] cr, input logic signed [19:0] cs,
                               input logic skip);
    q_t r, s, lo, hi;
    q_t rc[4], rd[4], sc[4], sd[4];
    int rs, ss, dv;
    bit ng;
    shape_res_t e;
    r = cr;
    s = cs;
    lo = -5 * (q_t'(1) <<< CoordFrac) - 1;
    hi = (q_t'(1) <<< CoordFrac) + 1;
    if (r < lo || r > hi || s < lo || s > hi) begin
      e = '0;
      e.status = 1'b1;
      e.last = 1'b1;
      expected_q.push_back(e);
      return;
    end
    cubics_of(r <<< (QFrac - CoordFrac), rc, rd);
    cubics_of(s <<< (QFrac - CoordFrac), sc, sd);
    for (int i = 0; i < 16; i++) begin
      basis_row(i, rs, ss, ng, dv);
      e = '0;
      e.index = 4'(i);
      e.value = scale_product(rc[rs], sc[ss], dv, ng);
      if (!skip) begin
        e.dr = scale_product(rd[rs], sc[ss], dv, ng);
        e.ds = scale_product(rc[rs], sd[ss], dv, ng);
        e.dvalid = 1'b1;
      end
      e.last = (i == 15);
      expected_q.push_back(e);
    end
  endtask

  always @(posedge clk_i) begin
    shape_res_t got, e;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_point(coord_r_i, coord_s_i, skip_derivatives_i);
      if (out_valid_i && out_ready_i) begin
        got = '{status_i, basis_index_i, shape_value_i, deriv_r_i, deriv_s_i,
                derivs_valid_i, last_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch, expected st=%0d idx=%0d v=%h dr=%h ds=%h dv=%0d l=%0d",
                     $time, e.status, e.index, e.value, e.dr, e.ds, e.dvalid, e.last);
            $display("%0t:           actual   st=%0d idx=%0d v=%h dr=%h ds=%h dv=%0d l=%0d",
                     $time, got.status, got.index, got.value, got.dr, got.ds, got.dvalid,
                     got.last);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end
endmodule

>>> tb/tb_cubic_upwind_shape_functions.sv
// Testbench top: drives points into the shape unit and reports the verdict.
`timescale 1ns / 100ps
module tb_cubic_upwind_shape_functions;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [19:0] coord_r_i = '0;
  logic signed [19:0] coord_s_i = '0;
  logic skip_derivatives_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic [3:0] basis_index_o;
  logic signed [31:0] shape_value_o, deriv_r_o, deriv_s_o;
  logic derivs_valid_o, last_o;
  int fail_count, pending;
  bit stim_done = 1'b0;

  localparam int OneC = 1 << 16;

  always #5 clk_i = ~clk_i;

  cubic_upwind_shape_functions dut (.*);

  cusf_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .coord_r_i, .coord_s_i,
    .skip_derivatives_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .basis_index_i(basis_index_o), .shape_value_i(shape_value_o),
    .deriv_r_i(deriv_r_o), .deriv_s_i(deriv_s_o), .derivs_valid_i(derivs_valid_o),
    .last_i(last_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Present one point and hold it until it is taken.
  task automatic send_point(input logic signed [19:0] r, input logic signed [19:0] s,
                            input logic skip);
    in_valid_i <= 1'b1;
    coord_r_i <= r;
    coord_s_i <= s;
    skip_derivatives_i <= skip;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Mostly in-range coordinates, with a slice of anything the field allows.
  function automatic logic signed [19:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 20'($urandom);
    if (pick == 1) return 20'($urandom_range(0, 4) - 2 + (($urandom & 1) ? OneC : -5 * OneC));
    return 20'(int'($urandom_range(0, 6 * OneC + 2)) - 5 * OneC - 1);
  endfunction

  // Receiver stall pattern: stretches of always-ready alternate with random stalls.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) < 8) out_ready_i <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_ready_i <= ~out_ready_i;
    else out_ready_i <= out_ready_i | ($urandom_range(0, 2) != 0);
  end

  initial begin
    logic signed [19:0] edge_vals[10];
    int burst, wait_cycles;
    edge_vals = '{20'(-5 * OneC - 2), 20'(-5 * OneC - 1), 20'(-5 * OneC), 20'(-3 * OneC),
                  20'(-OneC), 20'sd0, 20'(OneC), 20'(OneC + 1), 20'(OneC + 2),
                  20'sh7ffff};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_point(-20'sh80000, 20'sd0, 1'b0);
    for (int i = 0; i < 10; i++) send_point(edge_vals[i], edge_vals[9 - i], i[0]);
    for (int i = 0; i < 10; i++) send_point(edge_vals[i], edge_vals[(i + 3) % 10], !i[0]);
    for (int n = 0; n < 200; ) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst; b++, n++)
        send_point(rand_coord(), rand_coord(), $urandom_range(0, 3) == 0);
      in_valid_i <= 1'b0;
      wait_cycles = $urandom_range(0, 20);
      repeat (wait_cycles) @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    stim_done = 1'b1;
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    if (!stim_done) begin
      $display("FAIL");
      $finish;
    end
  end
endmodule
